@@ src/k_weighted_loudness_energy_meter_unit_defines.svh @@
`ifndef K_WEIGHTED_LOUDNESS_ENERGY_METER_UNIT_DEFINES_SVH
`define K_WEIGHTED_LOUDNESS_ENERGY_METER_UNIT_DEFINES_SVH

// Same-cycle implication, checked on i_clk outside reset.
`define KWL_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on i_clk outside reset.
`define KWL_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ src/kwl_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package kwl_pkg;

    localparam int CFG_INDEX_W = 4;
    localparam int CFG_DATA_W  = 16;

    localparam logic [CFG_INDEX_W-1:0] CFG_SUB_BLOCK_LENGTH = 4'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_STEREO_MODE      = 4'd1;

    localparam logic [15:0] LEN_RESET = 16'd4800;

    localparam logic signed [59:0] SMAX60 = 60'sd549755813887;
    localparam logic signed [59:0] SMIN60 = -60'sd549755813888;

    typedef struct packed {
        logic signed [23:0] left_sample;
        logic signed [23:0] right_sample;
    } t_in_word;

    typedef struct packed {
        logic [43:0] k_mean_energy;
        logic [59:0] mid_energy_sum;
        logic [23:0] peak_magnitude;
        logic [15:0] block_number;
    } t_out_word;

    typedef enum logic [2:0] {
        ST_IDLE, ST_LOAD, ST_MUL, ST_RND, ST_APPLY, ST_SUM, ST_DIV, ST_EMIT
    } t_state;

    typedef enum logic [3:0] {
        OP_SHELF_Y, OP_SHELF_B1, OP_SHELF_Z1, OP_SHELF_B2, OP_SHELF_Z2,
        OP_MID_Y, OP_MID_Z1, OP_MID_Z2, OP_HP_Z1, OP_HP_Z2,
        OP_K_ENERGY, OP_MID_ENERGY
    } t_op;

    localparam int COEF_N = 10;
    localparam int CI_S0 = 0;
    localparam int CI_S1 = 1;
    localparam int CI_S2 = 2;
    localparam int CI_S3 = 3;
    localparam int CI_S4 = 4;
    localparam int CI_M0 = 5;
    localparam int CI_M3 = 6;
    localparam int CI_M4 = 7;
    localparam int CI_H1 = 8;
    localparam int CI_H2 = 9;

    typedef logic [COEF_N-1:0][63:0] t_coef_set;

    localparam logic [63:0] ONE56 = 64'h0100_0000_0000_0000;
    localparam logic [63:0] PI56  = 64'h0324_3F6A_8885_A308;
    localparam logic [63:0] E12   = 64'd1000000000000;
    localparam logic [63:0] E15   = 64'd1000000000000000;

    function automatic logic [63:0] mul_shr(input logic [63:0] a, input logic [63:0] b,
                                            input int sh);
        logic [127:0] p;
        p = {64'd0, a} * {64'd0, b};
        p = p + (128'd1 << (sh - 1));
        return p[63+sh -: 64];
    endfunction

    function automatic logic [63:0] mag64(input logic signed [63:0] v);
        return v < 0 ? 64'(-v) : 64'(v);
    endfunction

    function automatic logic signed [63:0] smul(input logic signed [63:0] a,
                                                input logic signed [63:0] b, input int sh);
        logic [63:0] r;
        r = mul_shr(mag64(a), mag64(b), sh);
        return ((a < 0) != (b < 0)) ? -$signed(r) : $signed(r);
    endfunction

    function automatic logic [63:0] div_frac(input logic [63:0] n, input logic [63:0] d,
                                             input int bits);
        logic [127:0] num;
        logic [127:0] q;
        logic [64:0]  rem;
        num = {64'd0, n} << bits;
        q   = '0;
        rem = '0;
        for (int i = 127; i >= 0; i--) begin
            rem = {rem[63:0], num[i]};
            q   = q << 1;
            if (rem >= {1'b0, d}) begin
                rem  = rem - {1'b0, d};
                q[0] = 1'b1;
            end
        end
        return q[63:0];
    endfunction

    function automatic logic signed [63:0] sdiv_c(input logic signed [63:0] v,
                                                  input logic [63:0] d);
        logic [63:0] q;
        q = div_frac(mag64(v), d, 0);
        return v < 0 ? -$signed(q) : $signed(q);
    endfunction

    function automatic logic signed [63:0] dec56(input logic [63:0] e15);
        return $signed(div_frac(e15, E15, 56));
    endfunction

    function automatic logic signed [63:0] tan56(input logic [63:0] f0, input int rate);
        logic [63:0]        ratio;
        logic signed [63:0] th;
        logic signed [63:0] th2;
        logic signed [63:0] s;
        logic signed [63:0] c;
        logic signed [63:0] ts;
        logic signed [63:0] tc;
        ratio = div_frac(f0, 64'(rate) * E12, 56);
        th    = smul($signed(PI56), $signed(ratio), 56);
        th2   = smul(th, th, 56);
        s     = th;
        c     = $signed(ONE56);
        ts    = th;
        tc    = $signed(ONE56);
        for (int n = 1; n <= 10; n++) begin
            ts = sdiv_c(smul(ts, th2, 56), 64'((2 * n) * (2 * n + 1)));
            tc = sdiv_c(smul(tc, th2, 56), 64'((2 * n - 1) * (2 * n)));
            if ((n & 1) != 0) begin
                s = s - ts;
                c = c - tc;
            end else begin
                s = s + ts;
                c = c + tc;
            end
        end
        return $signed(div_frac(s, c, 56));
    endfunction

    function automatic logic [63:0] to_coef(input logic signed [63:0] num,
                                            input logic signed [63:0] den, input int cfrac);
        logic [63:0] lim;
        logic [63:0] q;
        lim = 64'd1 << (cfrac + 1);
        q   = div_frac(mag64(num), den, cfrac);
        if (num < 0) begin
            return q > lim ? 64'(-$signed(lim)) : 64'(-$signed(q));
        end
        return q > lim - 64'd1 ? lim - 64'd1 : q;
    endfunction

    function automatic t_coef_set kwl_coefs(input int rate, input int cfrac);
        t_coef_set          cs;
        logic signed [63:0] k;
        logic signed [63:0] q;
        logic signed [63:0] kq;
        logic signed [63:0] k2;
        logic signed [63:0] n;
        logic signed [63:0] vh;
        logic signed [63:0] vb;
        logic signed [63:0] vbkq;
        logic signed [63:0] one;
        one  = $signed(ONE56);
        k    = tan56(64'd1681974450955532, rate);
        q    = dec56(64'd707175236955419);
        kq   = $signed(div_frac(k, q, 56));
        k2   = smul(k, k, 56);
        vh   = dec56(64'd1584864701130855);
        vb   = dec56(64'd1258720930232562);
        vbkq = smul(vb, kq, 56);
        n    = one + kq + k2;
        cs[CI_S0] = to_coef(vh + vbkq + k2, n, cfrac);
        cs[CI_S1] = to_coef(2 * (k2 - vh), n, cfrac);
        cs[CI_S2] = to_coef(vh - vbkq + k2, n, cfrac);
        cs[CI_S3] = to_coef(2 * (k2 - one), n, cfrac);
        cs[CI_S4] = to_coef(one - kq + k2, n, cfrac);

        k  = tan56(64'd2800000000000000, rate);
        q  = dec56(64'd600000000000000);
        kq = $signed(div_frac(k, q, 56));
        k2 = smul(k, k, 56);
        n  = one + kq + k2;
        cs[CI_M0] = to_coef(kq, n, cfrac);
        cs[CI_M3] = to_coef(2 * (k2 - one), n, cfrac);
        cs[CI_M4] = to_coef(one - kq + k2, n, cfrac);

        k  = tan56(64'd38135470876140, rate);
        q  = dec56(64'd500327037325395);
        kq = $signed(div_frac(k, q, 56));
        k2 = smul(k, k, 56);
        n  = one + kq + k2;
        cs[CI_H1] = to_coef(2 * (k2 - one), n, cfrac);
        cs[CI_H2] = to_coef(one - kq + k2, n, cfrac);
        return cs;
    endfunction

endpackage
`default_nettype wire

@@ src/k_weighted_loudness_energy_meter_unit.sv @@
// K-weighted loudness energy meter. Each input word is one stereo frame (mono mode copies the
// left sample into the right lane); every sub_block_length frames one output word carries the
// mean K-weighted energy, the 2.8 kHz band energy sum, the running peak and a block index. All
// filter products run through one shared radix-16 serial multiplier: 12 products per lane, each
// loaded, multiplied, rounded and applied in turn; the next input word is taken only once the
// frame is done. A frame that closes a sub-block adds a restoring divider for the mean, then
// loads the output register once it is free. Configuration writes are taken every cycle.
`timescale 1ns / 1ps
`default_nettype none
module k_weighted_loudness_energy_meter_unit #(
    parameter int SAMPLE_RATE      = 48000,
    parameter int COEFFICIENT_BITS = 32
) (
    input  wire                                   i_clk,
    input  wire                                   i_rst_n,
    input  wire                                   i_in_valid,
    output logic                                  o_in_ready,
    input  wire kwl_pkg::t_in_word                i_in_word,
    output logic                                  o_out_valid,
    input  wire                                   i_out_ready,
    output kwl_pkg::t_out_word                    o_out_word,
    input  wire                                   i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  wire [kwl_pkg::CFG_INDEX_W-1:0]        i_cfg_index,
    input  wire [kwl_pkg::CFG_DATA_W-1:0]         i_cfg_data
);
    import kwl_pkg::*;

    localparam int SW        = 40;
    localparam int MW        = 2 * SW;
    localparam int DIGITS    = SW / 4;
    localparam int PRW       = 57;
    localparam int CFRAC     = COEFFICIENT_BITS - 2;
    localparam int RATE_USED = (SAMPLE_RATE < 8000) ? 8000 :
                               ((SAMPLE_RATE > 192000) ? 192000 : SAMPLE_RATE);
    localparam t_coef_set COEF = kwl_coefs(RATE_USED, CFRAC);
    localparam logic [MW:0] HALF_C = (MW+1)'(1) << (CFRAC - 1);
    localparam logic [MW:0] HALF_E = (MW+1)'(1) << 23;

    function automatic logic signed [SW-1:0] coef(input int idx);
        return $signed(COEF[idx][SW-1:0]);
    endfunction

    function automatic logic signed [SW-1:0] sat40(input logic signed [59:0] v);
        if (v > SMAX60) begin
            return SMAX60[SW-1:0];
        end else if (v < SMIN60) begin
            return SMIN60[SW-1:0];
        end
        return v[SW-1:0];
    endfunction

    function automatic logic [SW-1:0] mag40(input logic signed [SW-1:0] v);
        return v[SW-1] ? SW'(-v) : SW'(v);
    endfunction

    function automatic logic [23:0] mag24(input logic signed [23:0] v);
        return v[23] ? 24'(-v) : 24'(v);
    endfunction

    function automatic logic [PRW-2:0] rmag_of(input logic signed [PRW-1:0] v);
        return v[PRW-2:0];
    endfunction

    t_state r_state, n_state;
    t_op    r_op, n_op;
    logic   r_lane, n_lane;
    logic [5:0] r_cnt, n_cnt;
    logic [15:0] r_len, n_len;
    logic r_stereo, n_stereo;
    logic signed [23:0] r_s [2], n_s [2];
    logic signed [SW-1:0] r_sz1 [2], n_sz1 [2], r_sz2 [2], n_sz2 [2];
    logic signed [SW-1:0] r_mz1 [2], n_mz1 [2], r_mz2 [2], n_mz2 [2];
    logic signed [SW-1:0] r_hz1 [2], n_hz1 [2], r_hz2 [2], n_hz2 [2];
    logic signed [SW-1:0] r_ys, n_ys, r_ym, n_ym, r_yk, n_yk;
    logic signed [PRW-1:0] r_t, n_t, r_p, n_p;
    logic [SW-1:0] r_ma, n_ma, r_mb, n_mb;
    logic r_neg, n_neg, r_energy, n_energy;
    logic [MW-1:0] r_prod, n_prod;
    logic [57:0] r_kadd, n_kadd, r_madd, n_madd;
    logic [59:0] r_ksum, n_ksum, r_msum, n_msum;
    logic [15:0] r_pos, n_pos, r_blk, n_blk;
    logic [23:0] r_peak, n_peak;
    logic [16:0] r_rem, n_rem, r_dlen, n_dlen;
    logic [59:0] r_dq, n_dq;
    logic r_ovalid, n_ovalid;
    t_out_word r_oword, n_oword;

    logic signed [SW-1:0] x, opa, opb;
    logic signed [59:0] pe, te;
    logic [MW:0] rnd;
    logic [PRW-2:0] rmag;
    logic [60:0] ksum_add, msum_add;
    logic [16:0] next_pos, len;
    logic [17:0] rem2;
    logic signed [23:0] right_in;
    logic [23:0] m0, m1;

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_ovalid;
    assign o_out_word  = r_oword;
    assign o_cfg_ready = 1'b1;

    always_comb begin
        n_state = r_state; n_op = r_op; n_lane = r_lane; n_cnt = r_cnt;
        n_len = r_len; n_stereo = r_stereo; n_s = r_s;
        n_sz1 = r_sz1; n_sz2 = r_sz2; n_mz1 = r_mz1; n_mz2 = r_mz2;
        n_hz1 = r_hz1; n_hz2 = r_hz2;
        n_ys = r_ys; n_ym = r_ym; n_yk = r_yk; n_t = r_t; n_p = r_p;
        n_ma = r_ma; n_mb = r_mb; n_neg = r_neg; n_energy = r_energy; n_prod = r_prod;
        n_kadd = r_kadd; n_madd = r_madd; n_ksum = r_ksum; n_msum = r_msum;
        n_pos = r_pos; n_blk = r_blk; n_peak = r_peak;
        n_rem = r_rem; n_dlen = r_dlen; n_dq = r_dq;
        n_ovalid = r_ovalid; n_oword = r_oword;

        x        = SW'(r_s[r_lane]) <<< 9;
        pe       = 60'(r_p);
        te       = 60'(r_t);
        opa      = '0;
        opb      = '0;
        rnd      = '0;
        rmag     = '0;
        ksum_add = {1'b0, r_ksum} + 61'(r_kadd);
        msum_add = {1'b0, r_msum} + 61'(r_madd);
        next_pos = {1'b0, r_pos} + 17'd1;
        len      = (r_len == 16'd0) ? 17'h10000 : {1'b0, r_len};
        rem2     = {r_rem, r_dq[59]};
        right_in = r_stereo ? i_in_word.right_sample : i_in_word.left_sample;
        m0       = mag24(i_in_word.left_sample);
        m1       = mag24(right_in);

        if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_SUB_BLOCK_LENGTH: n_len = i_cfg_data[15:0];
                CFG_STEREO_MODE:      n_stereo = i_cfg_data[0];
                default: ;
            endcase
        end

        if (r_ovalid && i_out_ready) begin
            n_ovalid = 1'b0;
        end

        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_s[0] = i_in_word.left_sample;
                    n_s[1] = right_in;
                    if (m0 > n_peak) begin
                        n_peak = m0;
                    end
                    if (m1 > n_peak) begin
                        n_peak = m1;
                    end
                    n_kadd  = '0;
                    n_madd  = '0;
                    n_lane  = 1'b0;
                    n_op    = OP_SHELF_Y;
                    n_state = ST_LOAD;
                end
            end
            ST_LOAD: begin
                case (r_op)
                    OP_SHELF_Y:    begin opa = coef(CI_S0); opb = x;    end
                    OP_SHELF_B1:   begin opa = coef(CI_S1); opb = x;    end
                    OP_SHELF_Z1:   begin opa = coef(CI_S3); opb = r_ys; end
                    OP_SHELF_B2:   begin opa = coef(CI_S2); opb = x;    end
                    OP_SHELF_Z2:   begin opa = coef(CI_S4); opb = r_ys; end
                    OP_MID_Y:      begin opa = coef(CI_M0); opb = x;    end
                    OP_MID_Z1:     begin opa = coef(CI_M3); opb = r_ym; end
                    OP_MID_Z2:     begin opa = coef(CI_M4); opb = r_ym; end
                    OP_HP_Z1:      begin opa = coef(CI_H1); opb = r_yk; end
                    OP_HP_Z2:      begin opa = coef(CI_H2); opb = r_yk; end
                    OP_K_ENERGY:   begin opa = r_yk;        opb = r_yk; end
                    OP_MID_ENERGY: begin opa = r_ym;        opb = r_ym; end
                    default:       begin opa = '0;          opb = '0;   end
                endcase
                n_ma     = mag40(opa);
                n_mb     = mag40(opb);
                n_neg    = opa[SW-1] ^ opb[SW-1];
                n_energy = (r_op == OP_K_ENERGY) || (r_op == OP_MID_ENERGY);
                n_prod   = '0;
                n_cnt    = 6'(DIGITS - 1);
                n_state  = ST_MUL;
            end
            ST_MUL: begin
                n_prod = (r_prod << 4) + MW'(r_ma * r_mb[SW-1 -: 4]);
                n_mb   = r_mb << 4;
                n_cnt  = r_cnt - 6'd1;
                if (r_cnt == 6'd0) begin
                    n_state = ST_RND;
                end
            end
            ST_RND: begin
                if (r_energy) begin
                    rnd = ({1'b0, r_prod} + HALF_E) >> 24;
                end else begin
                    rnd = ({1'b0, r_prod} + HALF_C) >> CFRAC;
                end
                rmag    = rnd[PRW-2:0];
                n_p     = r_neg ? -$signed({1'b0, rmag}) : $signed({1'b0, rmag});
                n_state = ST_APPLY;
            end
            ST_APPLY: begin
                case (r_op)
                    OP_SHELF_Y:  n_ys = sat40(pe + 60'(r_sz1[r_lane]));
                    OP_SHELF_B1: begin
                        n_t  = r_p;
                        n_yk = sat40(60'(r_ys) + 60'(r_hz1[r_lane]));
                    end
                    OP_SHELF_Z1: n_sz1[r_lane] = sat40(te - pe + 60'(r_sz2[r_lane]));
                    OP_SHELF_B2: n_t = r_p;
                    OP_SHELF_Z2: n_sz2[r_lane] = sat40(te - pe);
                    OP_MID_Y: begin
                        n_ym = sat40(pe + 60'(r_mz1[r_lane]));
                        n_t  = r_p;
                    end
                    OP_MID_Z1:   n_mz1[r_lane] = sat40(60'(r_mz2[r_lane]) - pe);
                    OP_MID_Z2:   n_mz2[r_lane] = sat40(-te - pe);
                    OP_HP_Z1:    n_hz1[r_lane] = sat40(-(60'(r_ys) <<< 1) - pe
                                                       + 60'(r_hz2[r_lane]));
                    OP_HP_Z2:    n_hz2[r_lane] = sat40(60'(r_ys) - pe);
                    OP_K_ENERGY: n_kadd = r_kadd + 58'(rmag_of(r_p));
                    OP_MID_ENERGY: n_madd = r_madd + 58'(rmag_of(r_p));
                    default: ;
                endcase
                if (r_op != OP_MID_ENERGY) begin
                    n_op    = t_op'(r_op + 4'd1);
                    n_state = ST_LOAD;
                end else if (!r_lane) begin
                    n_lane  = 1'b1;
                    n_op    = OP_SHELF_Y;
                    n_state = ST_LOAD;
                end else begin
                    n_state = ST_SUM;
                end
            end
            ST_SUM: begin
                n_ksum = ksum_add[60] ? '1 : ksum_add[59:0];
                n_msum = msum_add[60] ? '1 : msum_add[59:0];
                if (next_pos < len) begin
                    n_pos   = next_pos[15:0];
                    n_state = ST_IDLE;
                end else begin
                    n_dq    = ksum_add[60] ? '1 : ksum_add[59:0];
                    n_rem   = '0;
                    n_dlen  = len;
                    n_cnt   = 6'd59;
                    n_state = ST_DIV;
                end
            end
            ST_DIV: begin
                if (rem2 >= {1'b0, r_dlen}) begin
                    n_rem = 17'(rem2 - {1'b0, r_dlen});
                    n_dq  = {r_dq[58:0], 1'b1};
                end else begin
                    n_rem = rem2[16:0];
                    n_dq  = {r_dq[58:0], 1'b0};
                end
                n_cnt = r_cnt - 6'd1;
                if (r_cnt == 6'd0) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (!r_ovalid || i_out_ready) begin
                    n_oword.k_mean_energy  = (r_dq[59:44] != '0) ? '1 : r_dq[43:0];
                    n_oword.mid_energy_sum = r_msum;
                    n_oword.peak_magnitude = r_peak;
                    n_oword.block_number   = r_blk;
                    n_ovalid = 1'b1;
                    n_ksum   = '0;
                    n_msum   = '0;
                    n_pos    = '0;
                    n_blk    = r_blk + 16'd1;
                    n_state  = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_op     <= OP_SHELF_Y;
            r_lane   <= 1'b0;
            r_cnt    <= '0;
            r_len    <= LEN_RESET;
            r_stereo <= 1'b1;
            r_ksum   <= '0;
            r_msum   <= '0;
            r_pos    <= '0;
            r_blk    <= '0;
            r_peak   <= '0;
            r_ovalid <= 1'b0;
            for (int i = 0; i < 2; i++) begin
                r_sz1[i] <= '0;
                r_sz2[i] <= '0;
                r_mz1[i] <= '0;
                r_mz2[i] <= '0;
                r_hz1[i] <= '0;
                r_hz2[i] <= '0;
            end
        end else begin
            r_state  <= n_state;
            r_op     <= n_op;
            r_lane   <= n_lane;
            r_cnt    <= n_cnt;
            r_len    <= n_len;
            r_stereo <= n_stereo;
            r_ksum   <= n_ksum;
            r_msum   <= n_msum;
            r_pos    <= n_pos;
            r_blk    <= n_blk;
            r_peak   <= n_peak;
            r_ovalid <= n_ovalid;
            r_sz1    <= n_sz1;
            r_sz2    <= n_sz2;
            r_mz1    <= n_mz1;
            r_mz2    <= n_mz2;
            r_hz1    <= n_hz1;
            r_hz2    <= n_hz2;
        end
        r_s      <= n_s;
        r_ys     <= n_ys;
        r_ym     <= n_ym;
        r_yk     <= n_yk;
        r_t      <= n_t;
        r_p      <= n_p;
        r_ma     <= n_ma;
        r_mb     <= n_mb;
        r_neg    <= n_neg;
        r_energy <= n_energy;
        r_prod   <= n_prod;
        r_kadd   <= n_kadd;
        r_madd   <= n_madd;
        r_rem    <= n_rem;
        r_dlen   <= n_dlen;
        r_dq     <= n_dq;
        r_oword  <= n_oword;
    end

endmodule
`default_nettype wire

@@ src/kwl_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none
`include "k_weighted_loudness_energy_meter_unit_defines.svh"
module kwl_checker (
    input wire                             i_clk,
    input wire                             i_rst_n,
    input wire                             i_in_valid,
    input wire                             o_in_ready,
    input wire kwl_pkg::t_in_word          i_in_word,
    input wire                             o_out_valid,
    input wire                             i_out_ready,
    input wire kwl_pkg::t_out_word         o_out_word,
    input wire                             i_cfg_valid,
    input wire                             o_cfg_ready,
    input wire [kwl_pkg::CFG_INDEX_W-1:0]  i_cfg_index,
    input wire [kwl_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import kwl_pkg::*;

    `KWL_ASSERT_NEXT(a_out_hold, o_out_valid && !i_out_ready, o_out_valid, "output word dropped")
    `KWL_ASSERT_NEXT(a_busy_after_accept, i_in_valid && o_in_ready, !o_in_ready, "taken twice")
    `KWL_ASSERT_NOW(a_peak_range, o_out_valid, o_out_word.peak_magnitude <= 24'h800000, "peak")
    `KWL_ASSERT_NEXT(a_in_hold, i_in_valid && !o_in_ready, $stable(i_in_word), "input changed")
    `KWL_ASSERT_NOW(a_cfg_known, i_cfg_valid && o_cfg_ready, !$isunknown({i_cfg_index, i_cfg_data}), "cfg x")

endmodule

bind k_weighted_loudness_energy_meter_unit kwl_checker u_kwl_checker (.*);
`default_nettype wire

@@ tb/testbench.sv @@
`timescale 1ns / 1ps
module testbench;
    import kwl_pkg::*;

    localparam int TAP_FRAC = 30;
    localparam longint unsigned RATE = 48000;
    localparam logic [CFG_INDEX_W-1:0] CFG_UNUSED_INDEX = 4'd15;
    localparam logic signed [63:0] SIG_HI = 64'sd549755813887;
    localparam logic signed [63:0] SIG_LO = -64'sd549755813888;
    localparam logic [63:0] SUM_CAP = 64'h0FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] MEAN_CAP = 64'h0000_0FFF_FFFF_FFFF;
    localparam logic [63:0] Q56_ONE = 64'h0100_0000_0000_0000;
    localparam logic [63:0] Q56_PI = 64'h0324_3F6A_8885_A308;
    localparam logic [63:0] TEN_E12 = 64'd1000000000000;
    localparam logic [63:0] TEN_E15 = 64'd1000000000000000;
    localparam int SETTLE = 400;
    localparam int HOLD_CYCLES = 2000;
    localparam int WORD_TOTAL = 1650;

    typedef enum logic {ROW_WORD, ROW_CFG} t_row_kind;
    typedef struct packed {
        t_row_kind              kind;
        logic [CFG_INDEX_W-1:0] idx;
        logic [CFG_DATA_W-1:0]  data;
        logic signed [23:0]     left;
        logic signed [23:0]     right;
        logic                   typed;
        t_out_word              want;
    } t_row;

    localparam int ROWS = 27;
    t_row plan [ROWS] = '{
        '{ROW_CFG,  CFG_SUB_BLOCK_LENGTH, 16'd1,      24'sd0,       24'sd0,       1'b0, '0},
        '{ROW_WORD, '0, '0, 24'sd0,        24'sd0,        1'b1, '0},
        '{ROW_WORD, '0, '0, 24'sd1,        -24'sd1,       1'b0, '0},
        '{ROW_WORD, '0, '0, 24'sd100,      24'sd200,      1'b0, '0},
        '{ROW_WORD, '0, '0, -24'sd4096,    24'sd4095,     1'b0, '0},
        '{ROW_CFG,  CFG_SUB_BLOCK_LENGTH, 16'd3,      24'sd0,       24'sd0,       1'b0, '0},
        '{ROW_WORD, '0, '0, 24'sd8388607,  24'sd8388607,  1'b0, '0},
        '{ROW_WORD, '0, '0, -24'sd8388608, -24'sd8388608, 1'b0, '0},
        '{ROW_WORD, '0, '0, 24'sd0,        24'sd0,        1'b0, '0},
        '{ROW_CFG,  CFG_STEREO_MODE,      16'hFFFE,   24'sd0,       24'sd0,       1'b0, '0},
        '{ROW_WORD, '0, '0, 24'sd12345,    24'sd8388607,  1'b0, '0},
        '{ROW_WORD, '0, '0, -24'sd8388608, 24'sd0,        1'b0, '0},
        '{ROW_WORD, '0, '0, 24'sd1,        -24'sd8388608, 1'b0, '0},
        '{ROW_CFG,  CFG_UNUSED_INDEX,     16'hFFFF,   24'sd0,       24'sd0,       1'b0, '0},
        '{ROW_CFG,  CFG_STEREO_MODE,      16'h0001,   24'sd0,       24'sd0,       1'b0, '0},
        '{ROW_CFG,  CFG_SUB_BLOCK_LENGTH, 16'd0,      24'sd0,       24'sd0,       1'b0, '0},
        '{ROW_WORD, '0, '0, 24'sd5000,     -24'sd5000,    1'b0, '0},
        '{ROW_WORD, '0, '0, -24'sd1,       24'sd1,        1'b0, '0},
        '{ROW_CFG,  CFG_SUB_BLOCK_LENGTH, 16'd1,      24'sd0,       24'sd0,       1'b0, '0},
        '{ROW_WORD, '0, '0, 24'sd300000,   -24'sd300000,  1'b0, '0},
        '{ROW_CFG,  CFG_SUB_BLOCK_LENGTH, 16'd65535,  24'sd0,       24'sd0,       1'b0, '0},
        '{ROW_WORD, '0, '0, 24'sd42,       -24'sd42,      1'b0, '0},
        '{ROW_WORD, '0, '0, -24'sd8388608, 24'sd8388607,  1'b0, '0},
        '{ROW_CFG,  CFG_SUB_BLOCK_LENGTH, 16'd2,      24'sd0,       24'sd0,       1'b0, '0},
        '{ROW_WORD, '0, '0, 24'sd7,        24'sd7,        1'b0, '0},
        '{ROW_WORD, '0, '0, -24'sd7,       24'sd3,        1'b0, '0},
        '{ROW_CFG,  CFG_SUB_BLOCK_LENGTH, LEN_RESET,  24'sd0,       24'sd0,       1'b0, '0}
    };

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_in_valid;
    logic                   o_in_ready;
    t_in_word               i_in_word;
    logic                   o_out_valid;
    logic                   i_out_ready;
    t_out_word              o_out_word;
    logic                   i_cfg_valid;
    logic                   o_cfg_ready;
    logic [CFG_INDEX_W-1:0] i_cfg_index;
    logic [CFG_DATA_W-1:0]  i_cfg_data;

    k_weighted_loudness_energy_meter_unit DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready), .i_in_word(i_in_word),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready), .o_out_word(o_out_word),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    logic signed [63:0] shelf_tap [5];
    logic signed [63:0] band_tap [5];
    logic signed [63:0] hp_a1;
    logic signed [63:0] hp_a2;

    logic signed [63:0] shelf_z1 [2];
    logic signed [63:0] shelf_z2 [2];
    logic signed [63:0] band_z1 [2];
    logic signed [63:0] band_z2 [2];
    logic signed [63:0] hp_z1 [2];
    logic signed [63:0] hp_z2 [2];
    logic [63:0]        k_sum;
    logic [63:0]        band_sum;
    logic [63:0]        position;
    logic [63:0]        peak;
    logic [15:0]        block_idx;
    logic [15:0]        len_reg;
    logic               stereo_reg;

    t_out_word block_results [$];
    int        errors;
    bit        quiet;
    bit        hold_req;
    bit        cur_typed;
    t_out_word cur_want;
    int        words_sent;

    function automatic logic [63:0] round_shift_product(input logic [63:0] a,
                                                        input logic [63:0] b, input int sh);
        logic [127:0] p;
        p = {64'd0, a} * {64'd0, b};
        p = p + (128'd1 << (sh - 1));
        p = p >> sh;
        return p[63:0];
    endfunction

    function automatic logic [63:0] magnitude(input logic signed [63:0] v);
        return v < 0 ? 64'(-v) : 64'(v);
    endfunction

    function automatic logic signed [63:0] signed_scale(input logic signed [63:0] a,
                                                        input logic signed [63:0] b,
                                                        input int sh);
        logic signed [63:0] r;
        r = $signed(round_shift_product(magnitude(a), magnitude(b), sh));
        return ((a < 0) != (b < 0)) ? -r : r;
    endfunction

    function automatic logic [63:0] frac_quotient(input logic [63:0] n, input logic [63:0] d,
                                                  input int bits);
        logic [127:0] w;
        w = ({64'd0, n} << bits) / {64'd0, d};
        return w[63:0];
    endfunction

    function automatic logic signed [63:0] tan_q56(input logic [63:0] f0);
        logic [63:0]        ratio;
        logic signed [63:0] th;
        logic signed [63:0] th2;
        logic signed [63:0] s;
        logic signed [63:0] c;
        logic signed [63:0] ts;
        logic signed [63:0] tc;
        logic signed [63:0] dv;
        ratio = frac_quotient(f0, RATE * TEN_E12, 56);
        th = signed_scale($signed(Q56_PI), $signed(ratio), 56);
        th2 = signed_scale(th, th, 56);
        s = th;
        c = $signed(Q56_ONE);
        ts = th;
        tc = $signed(Q56_ONE);
        for (int n = 1; n <= 10; n++) begin
            dv = (2 * n) * (2 * n + 1);
            ts = signed_scale(ts, th2, 56) / dv;
            dv = (2 * n - 1) * (2 * n);
            tc = signed_scale(tc, th2, 56) / dv;
            if (n % 2 == 1) begin
                s = s - ts;
                c = c - tc;
            end else begin
                s = s + ts;
                c = c + tc;
            end
        end
        return $signed(frac_quotient(s, c, 56));
    endfunction

    function automatic logic signed [63:0] quantize_tap(input logic signed [63:0] num,
                                                        input logic signed [63:0] den);
        logic [63:0] lim;
        logic [63:0] q;
        lim = 64'd1 << (TAP_FRAC + 1);
        q = frac_quotient(magnitude(num), den, TAP_FRAC);
        if (num < 0) return q > lim ? -$signed(lim) : -$signed(q);
        return q > lim - 1 ? $signed(lim - 1) : $signed(q);
    endfunction

    task automatic derive_taps;
        logic signed [63:0] k;
        logic signed [63:0] q;
        logic signed [63:0] kq;
        logic signed [63:0] k2;
        logic signed [63:0] n;
        logic signed [63:0] vh;
        logic signed [63:0] vb;
        logic signed [63:0] vbkq;
        logic signed [63:0] one;
        one = $signed(Q56_ONE);
        k = tan_q56(64'd1681974450955532);
        q = $signed(frac_quotient(64'd707175236955419, TEN_E15, 56));
        kq = $signed(frac_quotient(k, q, 56));
        k2 = signed_scale(k, k, 56);
        vh = $signed(frac_quotient(64'd1584864701130855, TEN_E15, 56));
        vb = $signed(frac_quotient(64'd1258720930232562, TEN_E15, 56));
        vbkq = signed_scale(vb, kq, 56);
        n = one + kq + k2;
        shelf_tap[0] = quantize_tap(vh + vbkq + k2, n);
        shelf_tap[1] = quantize_tap(2 * (k2 - vh), n);
        shelf_tap[2] = quantize_tap(vh - vbkq + k2, n);
        shelf_tap[3] = quantize_tap(2 * (k2 - one), n);
        shelf_tap[4] = quantize_tap(one - kq + k2, n);
        k = tan_q56(64'd2800000000000000);
        q = $signed(frac_quotient(64'd600000000000000, TEN_E15, 56));
        kq = $signed(frac_quotient(k, q, 56));
        k2 = signed_scale(k, k, 56);
        n = one + kq + k2;
        band_tap[0] = quantize_tap(kq, n);
        band_tap[1] = 0;
        band_tap[2] = -band_tap[0];
        band_tap[3] = quantize_tap(2 * (k2 - one), n);
        band_tap[4] = quantize_tap(one - kq + k2, n);
        k = tan_q56(64'd38135470876140);
        q = $signed(frac_quotient(64'd500327037325395, TEN_E15, 56));
        kq = $signed(frac_quotient(k, q, 56));
        k2 = signed_scale(k, k, 56);
        n = one + kq + k2;
        hp_a1 = quantize_tap(2 * (k2 - one), n);
        hp_a2 = quantize_tap(one - kq + k2, n);
    endtask

    function automatic logic signed [63:0] clip40(input logic signed [63:0] v);
        if (v > SIG_HI) return SIG_HI;
        if (v < SIG_LO) return SIG_LO;
        return v;
    endfunction

    task automatic run_biquad(input logic signed [63:0] c [5], input logic signed [63:0] x,
                              inout logic signed [63:0] z1, inout logic signed [63:0] z2,
                              output logic signed [63:0] y);
        y = clip40(signed_scale(c[0], x, TAP_FRAC) + z1);
        z1 = clip40(signed_scale(c[1], x, TAP_FRAC) - signed_scale(c[3], y, TAP_FRAC) + z2);
        z2 = clip40(signed_scale(c[2], x, TAP_FRAC) - signed_scale(c[4], y, TAP_FRAC));
    endtask

    task automatic meter_frame(input logic signed [23:0] l, input logic signed [23:0] r,
                               output bit closes, output t_out_word w);
        logic signed [63:0] s [2];
        logic signed [63:0] x;
        logic signed [63:0] ys;
        logic signed [63:0] ym;
        logic signed [63:0] yk;
        logic signed [63:0] t1;
        logic signed [63:0] t2;
        logic [63:0]        kadd;
        logic [63:0]        madd;
        logic [63:0]        len;
        logic [63:0]        mean;
        s[0] = l;
        s[1] = stereo_reg ? r : l;
        kadd = 0;
        madd = 0;
        for (int ln = 0; ln < 2; ln++) begin
            x = s[ln] * 512;
            t1 = shelf_z1[ln];
            t2 = shelf_z2[ln];
            run_biquad(shelf_tap, x, t1, t2, ys);
            shelf_z1[ln] = t1;
            shelf_z2[ln] = t2;
            t1 = band_z1[ln];
            t2 = band_z2[ln];
            run_biquad(band_tap, x, t1, t2, ym);
            band_z1[ln] = t1;
            band_z2[ln] = t2;
            yk = clip40(ys + hp_z1[ln]);
            hp_z1[ln] = clip40(-2 * ys - signed_scale(hp_a1, yk, TAP_FRAC) + hp_z2[ln]);
            hp_z2[ln] = clip40(ys - signed_scale(hp_a2, yk, TAP_FRAC));
            kadd += round_shift_product(magnitude(yk), magnitude(yk), 24);
            madd += round_shift_product(magnitude(ym), magnitude(ym), 24);
            if (magnitude(s[ln]) > peak) peak = magnitude(s[ln]);
        end
        k_sum = k_sum + kadd;
        if (k_sum > SUM_CAP) k_sum = SUM_CAP;
        band_sum = band_sum + madd;
        if (band_sum > SUM_CAP) band_sum = SUM_CAP;
        len = len_reg == 0 ? 64'd65536 : 64'(len_reg);
        closes = 0;
        w = '0;
        if (position + 1 < len) begin
            position = position + 1;
        end else begin
            mean = k_sum / len;
            w.k_mean_energy = mean > MEAN_CAP ? MEAN_CAP[43:0] : mean[43:0];
            w.mid_energy_sum = band_sum[59:0];
            w.peak_magnitude = peak[23:0];
            w.block_number = block_idx;
            block_idx = block_idx + 1;
            k_sum = 0;
            band_sum = 0;
            position = 0;
            closes = 1;
        end
    endtask

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        errors++;
        $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
    endtask

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        bit        closes;
        t_out_word w;
        t_out_word e;
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) begin
                if (i_cfg_index == CFG_SUB_BLOCK_LENGTH) len_reg = i_cfg_data;
                else if (i_cfg_index == CFG_STEREO_MODE) stereo_reg = i_cfg_data[0];
            end
            if (i_in_valid && o_in_ready) begin
                meter_frame(i_in_word.left_sample, i_in_word.right_sample, closes, w);
                if (cur_typed) begin
                    if (!closes) report_mismatch("typed row closes no block", 0, 1);
                    else w = cur_want;
                end
                if (closes) block_results = {block_results, w};
            end
            if (o_out_valid && i_out_ready) begin
                if (block_results.size() == 0) begin
                    report_mismatch("unexpected word", 0, 0);
                end else begin
                    e = block_results.pop_front();
                    if (o_out_word.k_mean_energy !== e.k_mean_energy)
                        report_mismatch("k_mean_energy", o_out_word.k_mean_energy,
                                        e.k_mean_energy);
                    if (o_out_word.mid_energy_sum !== e.mid_energy_sum)
                        report_mismatch("mid_energy_sum", o_out_word.mid_energy_sum,
                                        e.mid_energy_sum);
                    if (o_out_word.peak_magnitude !== e.peak_magnitude)
                        report_mismatch("peak_magnitude", o_out_word.peak_magnitude,
                                        e.peak_magnitude);
                    if (o_out_word.block_number !== e.block_number)
                        report_mismatch("block_number", o_out_word.block_number,
                                        e.block_number);
                end
            end
        end
    end

    initial begin
        i_out_ready = 0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                i_out_ready <= 0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                hold_req = 0;
            end else begin
                i_out_ready <= quiet || $urandom_range(0, 99) >= 12;
            end
        end
    end

    task automatic send_word(input logic signed [23:0] l, input logic signed [23:0] r,
                             input bit typed, input t_out_word want);
        if (!quiet && $urandom_range(0, 99) < 12) begin
            i_in_valid <= 0;
            repeat ($urandom_range(1, 8)) @(negedge i_clk);
        end
        cur_typed = typed;
        cur_want = want;
        i_in_valid <= 1;
        i_in_word.left_sample <= l;
        i_in_word.right_sample <= r;
        do @(posedge i_clk); while (!o_in_ready);
        @(negedge i_clk);
        words_sent++;
    endtask

    task automatic settle;
        i_in_valid <= 0;
        cur_typed = 0;
        while (block_results.size() != 0) @(negedge i_clk);
        repeat (SETTLE) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] d);
        settle();
        i_cfg_valid <= 1;
        i_cfg_index <= idx;
        i_cfg_data <= d;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 0;
    endtask

    function automatic logic signed [23:0] pick_sample();
        case ($urandom_range(0, 5))
            0: return $urandom_range(0, 1) ? 24'sh7FFFFF : 24'sh800000;
            1, 2: return 24'($signed($urandom_range(0, 1023)) - 512);
            default: return 24'($urandom);
        endcase
    endfunction

    initial begin
        int phase;
        int count;
        int pick;
        errors = 0;
        words_sent = 0;
        quiet = 0;
        hold_req = 0;
        cur_typed = 0;
        i_rst_n = 0;
        i_in_valid = 0;
        i_in_word = '0;
        i_cfg_valid = 0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        derive_taps();
        for (int ln = 0; ln < 2; ln++) begin
            shelf_z1[ln] = 0; shelf_z2[ln] = 0;
            band_z1[ln] = 0; band_z2[ln] = 0;
            hp_z1[ln] = 0; hp_z2[ln] = 0;
        end
        k_sum = 0;
        band_sum = 0;
        position = 0;
        peak = 0;
        block_idx = 0;
        len_reg = LEN_RESET;
        stereo_reg = 1;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1;
        @(negedge i_clk);

        for (int i = 0; i < ROWS; i++) begin
            if (plan[i].kind == ROW_CFG) write_reg(plan[i].idx, plan[i].data);
            else send_word(plan[i].left, plan[i].right, plan[i].typed, plan[i].want);
        end

        phase = 0;
        while (words_sent < WORD_TOTAL) begin
            pick = $urandom_range(0, 9);
            if (phase == 2 || pick == 8) write_reg(CFG_SUB_BLOCK_LENGTH, 16'd1);
            else if (pick < 6) write_reg(CFG_SUB_BLOCK_LENGTH, 16'($urandom_range(1, 4)));
            else if (pick < 8) write_reg(CFG_SUB_BLOCK_LENGTH, 16'($urandom_range(5, 24)));
            else write_reg(CFG_SUB_BLOCK_LENGTH, 16'($urandom_range(100, 300)));
            write_reg(CFG_STEREO_MODE, 16'($urandom));
            quiet = (phase == 0);
            if (phase == 2) hold_req = 1;
            count = $urandom_range(20, 120);
            for (int j = 0; j < count; j++)
                send_word(pick_sample(), pick_sample(), 1'b0, '0);
            phase++;
        end
        quiet = 0;
        settle();
        if (errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    initial begin
        #40_000_000;
        $display("tb: failure");
        $finish;
    end

endmodule
